[rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ssr_pkg.sv]
package ssr_pkg;

   // Command codes on req_cmd.
   localparam logic [1:0] CMD_SET_TARGET = 2'd0;
   localparam logic [1:0] CMD_RELEASE    = 2'd1;
   localparam logic [1:0] CMD_UPDATE     = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_STEP_SIZE     = 3'd0;
   localparam logic [2:0] CSR_MOVE_INTERVAL = 3'd1;
   localparam logic [2:0] CSR_MAX_MOVING    = 3'd2;
   localparam logic [2:0] CSR_SHOULDER_MASK = 3'd3;
   localparam logic [2:0] CSR_SHLD_PMIN     = 3'd4;
   localparam logic [2:0] CSR_SHLD_PMAX     = 3'd5;
   localparam logic [2:0] CSR_OTHER_PMIN    = 3'd6;
   localparam logic [2:0] CSR_OTHER_PMAX    = 3'd7;

   localparam logic [7:0] ANGLE_MAX  = 8'd180;
   localparam logic [7:0] ANGLE_HOME = 8'd90;

   localparam int CNT_W = 5;

   // Division by 180 as a multiplication by ceil(2^28 / 180); exact for
   // every dividend below 2^20.
   localparam int          RECIP_SHIFT = 28;
   localparam logic [20:0] RECIP_180   = 21'd1491309;

   typedef struct packed {
      logic [7:0]  step_size;
      logic [15:0] move_interval;
      logic [4:0]  max_moving;
      logic [15:0] shoulder_mask;
      logic [11:0] shoulder_pulse_min;
      logic [11:0] shoulder_pulse_max;
      logic [11:0] other_pulse_min;
      logic [11:0] other_pulse_max;
   } cfg_type;

   typedef struct packed {
      logic set_target;
      logic release_ch;
      logic frame_start;
      logic scan_step;
      logic map_mul1;
      logic map_mul2;
      logic map_done;
      logic flush;
   } ctrl_type;

   typedef struct packed {
      logic moved;
      logic scan_done;
      logic limit_hit;
   } stat_type;

endpackage

[rtl/ssr_csr.sv]
module ssr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output ssr_pkg::cfg_type  cfg
);

   ssr_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size          <= 8'd1;
         cfg_ff.move_interval      <= 16'd20;
         cfg_ff.max_moving         <= 5'd16;
         cfg_ff.shoulder_mask      <= 16'd0;
         cfg_ff.shoulder_pulse_min <= 12'd150;
         cfg_ff.shoulder_pulse_max <= 12'd600;
         cfg_ff.other_pulse_min    <= 12'd150;
         cfg_ff.other_pulse_max    <= 12'd600;
      end else if (csr_valid) begin
         case (csr_index)
            ssr_pkg::CSR_STEP_SIZE:     cfg_ff.step_size          <= csr_wdata[7:0];
            ssr_pkg::CSR_MOVE_INTERVAL: cfg_ff.move_interval      <= csr_wdata;
            ssr_pkg::CSR_MAX_MOVING:    cfg_ff.max_moving         <= csr_wdata[4:0];
            ssr_pkg::CSR_SHOULDER_MASK: cfg_ff.shoulder_mask      <= csr_wdata;
            ssr_pkg::CSR_SHLD_PMIN:     cfg_ff.shoulder_pulse_min <= csr_wdata[11:0];
            ssr_pkg::CSR_SHLD_PMAX:     cfg_ff.shoulder_pulse_max <= csr_wdata[11:0];
            ssr_pkg::CSR_OTHER_PMIN:    cfg_ff.other_pulse_min    <= csr_wdata[11:0];
            ssr_pkg::CSR_OTHER_PMAX:    cfg_ff.other_pulse_max    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

endmodule

[rtl/ssr_ctrl.sv]
`include "assert_macros.svh"

module ssr_ctrl #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_channel,
   input  ssr_pkg::stat_type  stat,
   output ssr_pkg::ctrl_type  ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MAP1,
      ST_MAP2,
      ST_MAP3,
      ST_FLUSH
   } state_type;

   localparam logic [4:0] NCH = 5'(NUM_CHANNELS);

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      accept;
   logic      ch_ok;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;
   assign ch_ok  = {1'b0, req_channel} < NCH;

   always_comb begin
      ctrl     = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  ssr_pkg::CMD_SET_TARGET: ctrl.set_target = ch_ok;
                  ssr_pkg::CMD_RELEASE:    ctrl.release_ch = ch_ok;
                  ssr_pkg::CMD_UPDATE: begin
                     ctrl.frame_start = 1'b1;
                     state_in         = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // The frame limit is checked before each channel is looked at.
            if (stat.scan_done || stat.limit_hit) begin
               state_in = ST_FLUSH;
            end else begin
               ctrl.scan_step = 1'b1;
               if (stat.moved) begin
                  state_in = ST_MAP1;
               end
            end
         end
         ST_MAP1: begin
            ctrl.map_mul1 = 1'b1;
            state_in      = ST_MAP2;
         end
         ST_MAP2: begin
            ctrl.map_mul2 = 1'b1;
            state_in      = ST_MAP3;
         end
         ST_MAP3: begin
            ctrl.map_done = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_FLUSH: begin
            ctrl.flush = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   `SSR_ASSERT_NEXT(a_update_goes_busy, clock, reset, accept && req_cmd == ssr_pkg::CMD_UPDATE, busy_ff, "update transfer did not raise busy")
   `SSR_ASSERT_NEXT(a_flush_ends_frame, clock, reset, state_ff == ST_FLUSH, !busy_ff, "busy still high after the frame flush")

endmodule

[rtl/ssr_dpath.sv]
`include "assert_macros.svh"

module ssr_dpath #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ssr_pkg::cfg_type   cfg,
   input  ssr_pkg::ctrl_type  ctrl,
   output ssr_pkg::stat_type  stat,
   input  logic [3:0]         req_channel,
   input  logic signed [15:0] req_angle,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   output logic [3:0]         rsp_out_channel,
   output logic [11:0]        rsp_pulse_width,
   output logic               rsp_last
);

   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IW = $clog2(NUM_CHANNELS + 1);

   // Per-channel state.
   logic [7:0]              cur_ff [NUM_CHANNELS];
   logic [7:0]              tgt_ff [NUM_CHANNELS];
   logic [31:0]             lmt_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] rel_ff;

   // Frame walk.
   logic [31:0]              now_ff;
   logic [IW-1:0]            idx_ff;
   logic [ssr_pkg::CNT_W-1:0] cnt_ff;

   // Pulse mapping stages.
   logic [3:0]  map_ch_ff;
   logic [7:0]  map_ang_ff;
   logic [11:0] map_lo_ff;
   logic [11:0] span_mag_ff;
   logic        span_neg_ff;
   logic [19:0] mag_ff;
   logic [11:0] q_ff;

   // Result held back until it is known whether another one follows.
   logic        pend_valid_ff;
   logic [3:0]  pend_ch_ff;
   logic [11:0] pend_pw_ff;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_ch_ff;
   logic [11:0] rsp_pw_ff;
   logic        rsp_last_ff;

   logic [CW-1:0]     sel;
   logic [CW-1:0]     wsel;
   logic [3:0]        chan4;
   logic [7:0]        cur, tgt, gap, new_ang;
   logic              up, due, moved;
   logic [31:0]       elapsed;
   logic [7:0]        set_ang;
   logic [11:0]       lo, hi;
   logic signed [12:0] span;
   logic [11:0]       span_mag;
   logic [40:0]       recip_prod;
   logic [11:0]       pw;

   assign sel   = idx_ff[CW-1:0];
   assign wsel  = req_channel[CW-1:0];
   assign chan4 = 4'(idx_ff);

   always_comb begin
      cur     = cur_ff[sel];
      tgt     = tgt_ff[sel];
      elapsed = now_ff - lmt_ff[sel];
      due     = elapsed >= {16'd0, cfg.move_interval};
      moved   = !rel_ff[sel] && due && (cur != tgt);
      up      = cur < tgt;
      gap     = up ? (tgt - cur) : (cur - tgt);
      if (gap > cfg.step_size) begin
         new_ang = up ? (cur + cfg.step_size) : (cur - cfg.step_size);
      end else begin
         new_ang = tgt;
      end

      if (cfg.shoulder_mask[chan4]) begin
         lo = cfg.shoulder_pulse_min;
         hi = cfg.shoulder_pulse_max;
      end else begin
         lo = cfg.other_pulse_min;
         hi = cfg.other_pulse_max;
      end
      span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
      span_mag = span[12] ? 12'(-span) : span[11:0];

      if (req_angle[15]) begin
         set_ang = 8'd0;
      end else if (req_angle > 16'sd180) begin
         set_ang = ssr_pkg::ANGLE_MAX;
      end else begin
         set_ang = req_angle[7:0];
      end

      recip_prod = 41'(mag_ff) * 41'(ssr_pkg::RECIP_180);
      // The quotient is truncated toward zero, so the sign goes on afterwards.
      pw = span_neg_ff ? (map_lo_ff - q_ff) : (map_lo_ff + q_ff);
   end

   assign stat.moved     = moved;
   assign stat.scan_done = (idx_ff == IW'(NUM_CHANNELS));
   assign stat.limit_hit = (cnt_ff >= cfg.max_moving);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cur_ff[i] <= ssr_pkg::ANGLE_HOME;
            tgt_ff[i] <= ssr_pkg::ANGLE_HOME;
            lmt_ff[i] <= 32'd0;
         end
         rel_ff        <= '1;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.release_ch ||
                         ((ctrl.map_done || ctrl.flush) && pend_valid_ff);
         if (ctrl.set_target) begin
            tgt_ff[wsel] <= set_ang;
            rel_ff[wsel] <= 1'b0;
         end
         if (ctrl.release_ch) begin
            rel_ff[wsel] <= 1'b1;
         end
         if (ctrl.frame_start) begin
            idx_ff <= '0;
            cnt_ff <= '0;
         end
         if (ctrl.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (moved) begin
               cur_ff[sel] <= new_ang;
               lmt_ff[sel] <= now_ff;
               cnt_ff      <= cnt_ff + 1'b1;
            end
         end
         if (ctrl.map_done) begin
            pend_valid_ff <= 1'b1;
         end
         if (ctrl.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.frame_start) begin
         now_ff <= req_now_ms;
      end
      if (ctrl.scan_step) begin
         map_ch_ff   <= chan4;
         map_ang_ff  <= new_ang;
         map_lo_ff   <= lo;
         span_mag_ff <= span_mag;
         span_neg_ff <= span[12];
      end
      if (ctrl.map_mul1) begin
         mag_ff <= 20'(map_ang_ff * span_mag_ff);
      end
      if (ctrl.map_mul2) begin
         q_ff <= 12'(recip_prod >> ssr_pkg::RECIP_SHIFT);
      end
      if (ctrl.release_ch) begin
         rsp_ch_ff   <= req_channel;
         rsp_pw_ff   <= 12'd0;
         rsp_last_ff <= 1'b1;
      end
      if (ctrl.map_done) begin
         rsp_ch_ff   <= pend_ch_ff;
         rsp_pw_ff   <= pend_pw_ff;
         rsp_last_ff <= 1'b0;
         pend_ch_ff  <= map_ch_ff;
         pend_pw_ff  <= pw;
      end
      if (ctrl.flush) begin
         rsp_ch_ff   <= pend_ch_ff;
         rsp_pw_ff   <= pend_pw_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_pulse_width = rsp_pw_ff;
   assign rsp_last        = rsp_last_ff;

   `SSR_ASSERT_NEXT(a_flush_marks_last, clock, reset, ctrl.flush && pend_valid_ff, rsp_valid_ff && rsp_last_ff, "held result not sent as last at flush")
   `SSR_ASSERT_NEXT(a_map_fills_pending, clock, reset, ctrl.map_done, pend_valid_ff && !rsp_last_ff, "mapped pulse width not held back")

endmodule

[rtl/servo_slew_ramp_controller.sv]
// Slew-rate limiter for up to sixteen servo channels.
//
// Commands arrive on req_*: a command is taken at a clock edge with start high
// and busy low. Set target clamps req_angle to 0..180 and arms the channel; it
// takes effect at the transfer and returns nothing. Release disarms the
// channel and returns one result (pulse width 0, last set) in the next cycle.
// An update frame walks the channels in order, one per cycle, but pauses at
// each channel that moves while its angle is mapped in ST_MAP1 to ST_MAP3;
// busy stays high until the walk ends and the frame is flushed; the walk
// ends early when the per-frame move limit is reached. Set target and release
// can be issued every cycle while busy is low.
// Each result is shown for one cycle with rsp_valid high; the receiver cannot
// hold it off. A moved channel's result comes out when the next one has been
// mapped or when the walk ends, so rsp_last marks the frame's final result.
// Configuration registers are written over csr_* (always ready); the user must
// write them only while busy is low; the block does not enforce it. Reset puts
// all channels at 90 degrees, released, move time 0, and loads CSR defaults.
module servo_slew_ramp_controller #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_channel,
   input  logic signed [15:0] req_angle,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   output logic [3:0]         rsp_out_channel,
   output logic [11:0]        rsp_pulse_width,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   ssr_pkg::cfg_type  cfg;
   ssr_pkg::ctrl_type ctrl;
   ssr_pkg::stat_type stat;

   ssr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssr_ctrl #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .stat        (stat),
      .ctrl        (ctrl)
   );

   ssr_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_channel     (req_channel),
      .req_angle       (req_angle),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_out_channel (rsp_out_channel),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_last        (rsp_last)
   );

endmodule
